// ----- hw/rtl/undirected_csr_builder_defines.svh -----
// Assertion macros shared by the CSR builder modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef UNDIRECTED_CSR_BUILDER_DEFINES_SVH
`define UNDIRECTED_CSR_BUILDER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define UCSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define UCSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ucsr_pkg.sv -----
// Shared types, widths and codes for the undirected CSR builder.
// Used by the controller, the datapath and the top level; depends on nothing.
package ucsr_pkg;

    // Field widths.
    localparam int ACT_W      = 3;
    localparam int NODE_W     = 10;
    localparam int WEIGHT_W   = 32;
    localparam int SLOT_W     = 13;
    localparam int STATUS_W   = 3;
    localparam int DEG_W      = 14;
    localparam int NCNT_W     = 11;
    localparam int ECNT_W     = 14;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 88;

    // Default sizes.
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MISS = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 32'h0000_0001;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_PHASE     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

    // Datapath step codes issued by the controller.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_NONE    = 5'd0;
    localparam logic [STEP_W-1:0] ST_LOAD    = 5'd1;
    localparam logic [STEP_W-1:0] ST_EXEC    = 5'd2;
    localparam logic [STEP_W-1:0] ST_CLR     = 5'd3;
    localparam logic [STEP_W-1:0] ST_CNT_E   = 5'd4;
    localparam logic [STEP_W-1:0] ST_CNT_RA  = 5'd5;
    localparam logic [STEP_W-1:0] ST_CNT_WA  = 5'd6;
    localparam logic [STEP_W-1:0] ST_CNT_RB  = 5'd7;
    localparam logic [STEP_W-1:0] ST_CNT_WB  = 5'd8;
    localparam logic [STEP_W-1:0] ST_PF_RD   = 5'd9;
    localparam logic [STEP_W-1:0] ST_PF_WR   = 5'd10;
    localparam logic [STEP_W-1:0] ST_SC_E    = 5'd11;
    localparam logic [STEP_W-1:0] ST_SC_RA   = 5'd12;
    localparam logic [STEP_W-1:0] ST_SC_WA   = 5'd13;
    localparam logic [STEP_W-1:0] ST_SC_RB   = 5'd14;
    localparam logic [STEP_W-1:0] ST_SC_WB   = 5'd15;
    localparam logic [STEP_W-1:0] ST_Q_RS    = 5'd16;
    localparam logic [STEP_W-1:0] ST_Q_RE    = 5'd17;
    localparam logic [STEP_W-1:0] ST_Q_CHK   = 5'd18;
    localparam logic [STEP_W-1:0] ST_SCAN_RD = 5'd19;
    localparam logic [STEP_W-1:0] ST_SCAN_CK = 5'd20;
    localparam logic [STEP_W-1:0] ST_ENT_RD  = 5'd21;
    localparam logic [STEP_W-1:0] ST_ENT_CAP = 5'd22;
    localparam logic [STEP_W-1:0] ST_OUT     = 5'd23;

    // Command from controller to datapath.
    typedef struct packed {
        logic [STEP_W-1:0] step;
    } ucsr_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic need_build;
        logic need_row;
        logic is_query;
        logic clr_last;
        logic edge_end;
        logic pf_end;
        logic q_fail;
        logic scan_end;
        logic scan_hit;
        logic out_free;
    } ucsr_sts_t;

endpackage

// ----- hw/rtl/ucsr_ctrl.sv -----
// Controller state machine for the undirected CSR builder.
// Depends on ucsr_pkg; drives the datapath through ucsr_cmd_t.
module ucsr_ctrl
    import ucsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ucsr_sts_t sts,
    output ucsr_cmd_t cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_EXEC    = 5'd1;
    localparam logic [4:0] S_CLR     = 5'd2;
    localparam logic [4:0] S_CNT_E   = 5'd3;
    localparam logic [4:0] S_CNT_RA  = 5'd4;
    localparam logic [4:0] S_CNT_WA  = 5'd5;
    localparam logic [4:0] S_CNT_RB  = 5'd6;
    localparam logic [4:0] S_CNT_WB  = 5'd7;
    localparam logic [4:0] S_PF_RD   = 5'd8;
    localparam logic [4:0] S_PF_WR   = 5'd9;
    localparam logic [4:0] S_SC_E    = 5'd10;
    localparam logic [4:0] S_SC_RA   = 5'd11;
    localparam logic [4:0] S_SC_WA   = 5'd12;
    localparam logic [4:0] S_SC_RB   = 5'd13;
    localparam logic [4:0] S_SC_WB   = 5'd14;
    localparam logic [4:0] S_Q_RS    = 5'd15;
    localparam logic [4:0] S_Q_RE    = 5'd16;
    localparam logic [4:0] S_Q_CHK   = 5'd17;
    localparam logic [4:0] S_SCAN_RD = 5'd18;
    localparam logic [4:0] S_SCAN_CK = 5'd19;
    localparam logic [4:0] S_ENT_RD  = 5'd20;
    localparam logic [4:0] S_ENT_CAP = 5'd21;
    localparam logic [4:0] S_OUT     = 5'd22;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_EXEC;
            S_EXEC:
            begin
                priority if (sts.need_build) state_next = S_CLR;
                else if (sts.need_row)       state_next = S_Q_RS;
                else                         state_next = S_OUT;
            end
            S_CLR:     if (sts.clr_last) state_next = S_CNT_E;
            S_CNT_E:   state_next = sts.edge_end ? S_PF_RD : S_CNT_RA;
            S_CNT_RA:  state_next = S_CNT_WA;
            S_CNT_WA:  state_next = S_CNT_RB;
            S_CNT_RB:  state_next = S_CNT_WB;
            S_CNT_WB:  state_next = S_CNT_E;
            S_PF_RD:   state_next = sts.pf_end ? S_SC_E : S_PF_WR;
            S_PF_WR:   state_next = S_PF_RD;
            S_SC_E:    state_next = sts.edge_end ? S_OUT : S_SC_RA;
            S_SC_RA:   state_next = S_SC_WA;
            S_SC_WA:   state_next = S_SC_RB;
            S_SC_RB:   state_next = S_SC_WB;
            S_SC_WB:   state_next = S_SC_E;
            S_Q_RS:    state_next = S_Q_RE;
            S_Q_RE:    state_next = S_Q_CHK;
            S_Q_CHK:
            begin
                priority if (sts.q_fail) state_next = S_OUT;
                else if (sts.is_query)   state_next = S_SCAN_RD;
                else                     state_next = S_ENT_RD;
            end
            S_SCAN_RD: state_next = sts.scan_end ? S_OUT : S_SCAN_CK;
            S_SCAN_CK: state_next = sts.scan_hit ? S_OUT : S_SCAN_RD;
            S_ENT_RD:  state_next = S_ENT_CAP;
            S_ENT_CAP: state_next = S_OUT;
            S_OUT:     if (sts.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Step code for the datapath.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:    cmd.step = s_tvalid ? ST_LOAD : ST_NONE;
            S_EXEC:    cmd.step = ST_EXEC;
            S_CLR:     cmd.step = ST_CLR;
            S_CNT_E:   cmd.step = ST_CNT_E;
            S_CNT_RA:  cmd.step = ST_CNT_RA;
            S_CNT_WA:  cmd.step = ST_CNT_WA;
            S_CNT_RB:  cmd.step = ST_CNT_RB;
            S_CNT_WB:  cmd.step = ST_CNT_WB;
            S_PF_RD:   cmd.step = ST_PF_RD;
            S_PF_WR:   cmd.step = ST_PF_WR;
            S_SC_E:    cmd.step = ST_SC_E;
            S_SC_RA:   cmd.step = ST_SC_RA;
            S_SC_WA:   cmd.step = ST_SC_WA;
            S_SC_RB:   cmd.step = ST_SC_RB;
            S_SC_WB:   cmd.step = ST_SC_WB;
            S_Q_RS:    cmd.step = ST_Q_RS;
            S_Q_RE:    cmd.step = ST_Q_RE;
            S_Q_CHK:   cmd.step = ST_Q_CHK;
            S_SCAN_RD: cmd.step = ST_SCAN_RD;
            S_SCAN_CK: cmd.step = ST_SCAN_CK;
            S_ENT_RD:  cmd.step = ST_ENT_RD;
            S_ENT_CAP: cmd.step = ST_ENT_CAP;
            S_OUT:     cmd.step = ST_OUT;
            default:   cmd.step = ST_NONE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/ucsr_datapath.sv -----
// Datapath of the undirected CSR builder: edge, row and entry memories,
// counters and the result register. Depends on ucsr_pkg and the defines header.
`include "undirected_csr_builder_defines.svh"
module ucsr_datapath
    import ucsr_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [ACT_W-1:0]      s_tuser,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  ucsr_cmd_t             cmd,
    output ucsr_sts_t             sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int EDGE_AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CW   = $clog2(MAX_EDGES + 1);
    localparam int ENTRY_CAP = 2 * MAX_EDGES;
    localparam int ENTRY_AW  = $clog2(ENTRY_CAP);
    localparam int ENTRY_CW  = $clog2(ENTRY_CAP + 1);
    localparam int ROW_DEPTH = MAX_NODES + 1;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);

    // Memories.
    logic [NODE_W-1:0]   esrc_mem [MAX_EDGES];
    logic [NODE_W-1:0]   edst_mem [MAX_EDGES];
    logic [WEIGHT_W-1:0] ewt_mem  [MAX_EDGES];
    logic [ENTRY_CW-1:0] row_mem  [ROW_DEPTH];
    logic [ENTRY_CW-1:0] cur_mem  [ROW_DEPTH];
    logic [NODE_W-1:0]   nb_mem   [ENTRY_CAP];
    logic [WEIGHT_W-1:0] ew_mem   [ENTRY_CAP];

    // Control state.
    logic                mode_reg;
    logic                built_reg;
    logic [EDGE_CW-1:0]  edge_total_reg;
    logic [NCNT_W-1:0]   node_total_reg;
    logic                m_tvalid_reg;

    // Working registers.
    logic [ACT_W-1:0]    act_reg;
    logic [NODE_W-1:0]   a_reg;
    logic [NODE_W-1:0]   b_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [EDGE_CW-1:0]  idx_reg;
    logic [NCNT_W-1:0]   ptr_reg;
    logic [ENTRY_CW-1:0] sum_reg;
    logic [ENTRY_CW-1:0] rs_reg;
    logic [ENTRY_CW-1:0] re_reg;
    logic [ENTRY_CW-1:0] scan_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [WEIGHT_W-1:0] res_w_reg;
    logic [NODE_W-1:0]   res_n_reg;
    logic [DEG_W-1:0]    res_d_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]   m_tuser_reg;

    // Registered memory read data.
    logic [NODE_W-1:0]   src_rd;
    logic [NODE_W-1:0]   dst_rd;
    logic [WEIGHT_W-1:0] w_rd;
    logic [ENTRY_CW-1:0] row_rd;
    logic [ENTRY_CW-1:0] cur_rd;
    logic [NODE_W-1:0]   nb_rd;
    logic [WEIGHT_W-1:0] ew_rd;

    // Memory port controls.
    logic                edge_we;
    logic                edge_re;
    logic                row_we;
    logic                row_re;
    logic [ROW_AW-1:0]   row_wa;
    logic [ROW_AW-1:0]   row_ra;
    logic [ENTRY_CW-1:0] row_wd;
    logic                cur_we;
    logic                cur_re;
    logic [ROW_AW-1:0]   cur_wa;
    logic [ROW_AW-1:0]   cur_ra;
    logic [ENTRY_CW-1:0] cur_wd;
    logic                ent_we;
    logic                ent_re;
    logic [ENTRY_AW-1:0] ent_wa;
    logic [ENTRY_AW-1:0] ent_ra;
    logic [NODE_W-1:0]   ent_nd;
    logic [ENTRY_CW-1:0] ent_rptr;

    // Decoded conditions.
    logic                add_bad_id;
    logic                add_full;
    logic [NODE_W-1:0]   add_max;
    logic [NCNT_W-1:0]   add_top;
    logic                row_ok;
    logic [ENTRY_CW-1:0] deg;
    logic                b_bad;
    logic                slot_bad;
    logic [WEIGHT_W-1:0] mode_w;
    logic                out_free;

    // Add checks.
    assign add_bad_id = (32'(a_reg) >= MAX_NODES) || (32'(b_reg) >= MAX_NODES);
    assign add_full   = (32'(edge_total_reg) >= MAX_EDGES);
    assign add_max    = (a_reg > b_reg) ? a_reg : b_reg;
    assign add_top    = NCNT_W'({1'b0, add_max}) + NCNT_W'(1);

    // Row checks, valid in the check step while row_rd holds the row end.
    assign row_ok   = built_reg && (NCNT_W'({1'b0, a_reg}) < node_total_reg);
    assign deg      = row_rd - rs_reg;
    assign b_bad    = (NCNT_W'({1'b0, b_reg}) >= node_total_reg);
    assign slot_bad = (32'(slot_reg) >= 32'(deg));
    assign mode_w   = mode_reg ? ew_rd : WEIGHT_ONE;
    assign ent_rptr = rs_reg + ENTRY_CW'(slot_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // Status to the controller.
    always_comb
    begin
        sts.need_build = (act_reg == ACT_BUILD) && !built_reg;
        sts.need_row   = ((act_reg == ACT_QUERY) || (act_reg == ACT_READ)) && built_reg;
        sts.is_query   = (act_reg == ACT_QUERY);
        sts.clr_last   = (ptr_reg == node_total_reg);
        sts.edge_end   = (idx_reg == edge_total_reg);
        sts.pf_end     = (ptr_reg > node_total_reg);
        sts.q_fail     = !row_ok || ((act_reg == ACT_QUERY) ? b_bad : slot_bad);
        sts.scan_end   = (scan_reg == re_reg);
        sts.scan_hit   = (nb_rd == b_reg);
        sts.out_free   = out_free;
    end

    // Memory port selection per step.
    always_comb
    begin
        edge_we = 1'b0;
        edge_re = 1'b0;
        row_we  = 1'b0;
        row_re  = 1'b0;
        row_wa  = ROW_AW'(ptr_reg);
        row_ra  = ROW_AW'(ptr_reg);
        row_wd  = '0;
        cur_we  = 1'b0;
        cur_re  = 1'b0;
        cur_wa  = ROW_AW'(ptr_reg);
        cur_ra  = ROW_AW'(src_rd);
        cur_wd  = '0;
        ent_we  = 1'b0;
        ent_re  = 1'b0;
        ent_wa  = cur_rd[ENTRY_AW-1:0];
        ent_ra  = scan_reg[ENTRY_AW-1:0];
        ent_nd  = dst_rd;
        unique case (cmd.step)
            ST_EXEC:
            begin
                edge_we = (act_reg == ACT_ADD) && !built_reg && !add_bad_id && !add_full;
            end
            ST_CLR:
            begin
                row_we = 1'b1;
                cur_we = 1'b1;
            end
            ST_CNT_E, ST_SC_E:
            begin
                edge_re = !sts.edge_end;
            end
            ST_CNT_RA:
            begin
                row_re = 1'b1;
                row_ra = ROW_AW'(NCNT_W'({1'b0, src_rd}) + NCNT_W'(1));
            end
            ST_CNT_WA:
            begin
                row_we = 1'b1;
                row_wa = ROW_AW'(NCNT_W'({1'b0, src_rd}) + NCNT_W'(1));
                row_wd = row_rd + ENTRY_CW'(1);
            end
            ST_CNT_RB:
            begin
                row_re = 1'b1;
                row_ra = ROW_AW'(NCNT_W'({1'b0, dst_rd}) + NCNT_W'(1));
            end
            ST_CNT_WB:
            begin
                row_we = 1'b1;
                row_wa = ROW_AW'(NCNT_W'({1'b0, dst_rd}) + NCNT_W'(1));
                row_wd = row_rd + ENTRY_CW'(1);
            end
            ST_PF_RD:
            begin
                row_re = !sts.pf_end;
            end
            ST_PF_WR:
            begin
                row_we = 1'b1;
                row_wd = sum_reg + row_rd;
                cur_we = 1'b1;
                cur_wd = sum_reg + row_rd;
            end
            ST_SC_RA:
            begin
                cur_re = 1'b1;
            end
            ST_SC_WA:
            begin
                cur_we = 1'b1;
                cur_wa = ROW_AW'(src_rd);
                cur_wd = cur_rd + ENTRY_CW'(1);
                ent_we = 1'b1;
            end
            ST_SC_RB:
            begin
                cur_re = 1'b1;
                cur_ra = ROW_AW'(dst_rd);
            end
            ST_SC_WB:
            begin
                cur_we = 1'b1;
                cur_wa = ROW_AW'(dst_rd);
                cur_wd = cur_rd + ENTRY_CW'(1);
                ent_we = 1'b1;
                ent_nd = src_rd;
            end
            ST_Q_RS:
            begin
                row_re = 1'b1;
                row_ra = ROW_AW'(a_reg);
            end
            ST_Q_RE:
            begin
                row_re = 1'b1;
                row_ra = ROW_AW'(NCNT_W'({1'b0, a_reg}) + NCNT_W'(1));
            end
            ST_SCAN_RD:
            begin
                ent_re = !sts.scan_end;
            end
            ST_ENT_RD:
            begin
                ent_re = 1'b1;
                ent_ra = ent_rptr[ENTRY_AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Edge store; a new edge goes to the slot after the last stored one.
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            esrc_mem[edge_total_reg[EDGE_AW-1:0]] <= a_reg;
            edst_mem[edge_total_reg[EDGE_AW-1:0]] <= b_reg;
            ewt_mem[edge_total_reg[EDGE_AW-1:0]]  <= mode_reg ? w_reg : WEIGHT_ONE;
        end
        if (edge_re)
        begin
            src_rd <= esrc_mem[idx_reg[EDGE_AW-1:0]];
            dst_rd <= edst_mem[idx_reg[EDGE_AW-1:0]];
            w_rd   <= ewt_mem[idx_reg[EDGE_AW-1:0]];
        end
    end

    // Row start store.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        if (row_re)
        begin
            row_rd <= row_mem[row_ra];
        end
    end

    // Fill cursor store.
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_wa] <= cur_wd;
        end
        if (cur_re)
        begin
            cur_rd <= cur_mem[cur_ra];
        end
    end

    // Row entry stores.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            nb_mem[ent_wa] <= ent_nd;
            ew_mem[ent_wa] <= w_rd;
        end
        if (ent_re)
        begin
            nb_rd <= nb_mem[ent_ra];
            ew_rd <= ew_mem[ent_ra];
        end
    end

    // Control state: mode, totals, built flag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            built_reg      <= 1'b0;
            edge_total_reg <= '0;
            node_total_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.step == ST_EXEC)
            begin
                if (act_reg == ACT_CLEAR)
                begin
                    edge_total_reg <= '0;
                    node_total_reg <= '0;
                    built_reg      <= 1'b0;
                end
                else if (edge_we)
                begin
                    edge_total_reg <= edge_total_reg + EDGE_CW'(1);
                    if (add_top > node_total_reg)
                    begin
                        node_total_reg <= add_top;
                    end
                end
            end
            if ((cmd.step == ST_SC_E) && sts.edge_end)
            begin
                built_reg <= 1'b1;
            end
            if ((cmd.step == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result.
    always_ff @(posedge clk)
    begin
        unique case (cmd.step)
            ST_LOAD:
            begin
                act_reg  <= s_tuser;
                a_reg    <= s_tdata[9:0];
                b_reg    <= s_tdata[19:10];
                w_reg    <= s_tdata[51:20];
                slot_reg <= s_tdata[64:52];
            end
            ST_EXEC:
            begin
                ptr_reg   <= '0;
                idx_reg   <= (act_reg == ACT_ADD) ? edge_total_reg : '0;
                res_w_reg <= (act_reg == ACT_QUERY) ? WEIGHT_MISS : '0;
                res_n_reg <= '0;
                res_d_reg <= '0;
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        priority if (built_reg) res_status_reg <= STS_PHASE;
                        else if (add_bad_id)    res_status_reg <= STS_RANGE;
                        else if (add_full)      res_status_reg <= STS_FULL;
                        else                    res_status_reg <= STS_OK;
                    end
                    ACT_BUILD:
                    begin
                        res_status_reg <= built_reg ? STS_PHASE : STS_OK;
                    end
                    ACT_QUERY, ACT_READ:
                    begin
                        res_status_reg <= STS_PHASE;
                    end
                    default:
                    begin
                        res_status_reg <= STS_OK;
                    end
                endcase
            end
            ST_CLR:
            begin
                ptr_reg <= ptr_reg + NCNT_W'(1);
                if (sts.clr_last)
                begin
                    idx_reg <= '0;
                end
            end
            ST_CNT_E:
            begin
                if (sts.edge_end)
                begin
                    ptr_reg <= NCNT_W'(1);
                    sum_reg <= '0;
                end
            end
            ST_CNT_WB, ST_SC_WB:
            begin
                idx_reg <= idx_reg + EDGE_CW'(1);
            end
            ST_PF_RD:
            begin
                if (sts.pf_end)
                begin
                    idx_reg <= '0;
                end
            end
            ST_PF_WR:
            begin
                sum_reg <= sum_reg + row_rd;
                ptr_reg <= ptr_reg + NCNT_W'(1);
            end
            ST_SC_E:
            begin
                if (sts.edge_end)
                begin
                    res_status_reg <= STS_OK;
                end
            end
            ST_Q_RE:
            begin
                rs_reg <= row_rd;
            end
            ST_Q_CHK:
            begin
                re_reg   <= row_rd;
                scan_reg <= rs_reg;
                res_d_reg <= row_ok ? DEG_W'(deg) : '0;
                if (sts.q_fail)
                begin
                    res_status_reg <= STS_RANGE;
                end
                else
                begin
                    res_status_reg <= sts.is_query ? STS_NOT_FOUND : STS_OK;
                end
            end
            ST_SCAN_CK:
            begin
                if (sts.scan_hit)
                begin
                    res_status_reg <= STS_OK;
                    res_w_reg      <= mode_w;
                end
                else
                begin
                    scan_reg <= scan_reg + ENTRY_CW'(1);
                end
            end
            ST_ENT_CAP:
            begin
                res_n_reg <= nb_rd;
                res_w_reg <= mode_w;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tuser_reg <= res_status_reg;
                    m_tdata_reg <= {7'd0,
                                    ECNT_W'({edge_total_reg, 1'b0}),
                                    node_total_reg,
                                    res_d_reg,
                                    res_n_reg,
                                    res_w_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks on the datapath.
    `UCSR_ASSERT_NOW(a_built_rise, $rose(built_reg), $past(cmd.step == ST_SC_E), "built set outside scatter end")
    `UCSR_ASSERT_NOW(a_edge_bound, 1'b1, 32'(edge_total_reg) <= MAX_EDGES, "edge total beyond store")
    `UCSR_ASSERT_NOW(a_scan_range, cmd.step == ST_SCAN_CK, scan_reg < re_reg, "scan beyond row end")
    `UCSR_ASSERT_NEXT(a_add_count, (cmd.step == ST_EXEC) && edge_we, edge_total_reg == $past(edge_total_reg) + EDGE_CW'(1), "edge add not counted")

endmodule

// ----- hw/rtl/undirected_csr_builder.sv -----
// Top level of the undirected CSR builder: controller plus datapath.
// Depends on ucsr_pkg, ucsr_ctrl and ucsr_datapath.
//
//  Channel   Direction  Payload
//  s_*       in         tuser: action; tdata: node_a, node_b, edge_weight_in, slot
//  m_*       out        tuser: status; tdata: weight, neighbour, degree, counts
//  cfg_*     in         weighted_mode, one bit
//
// Add, clear, an ignored code and a phase refusal go from the execute step straight to
// the output step; one input is worked on at a time.
// A build clears the rows, counts the degrees, forms the prefix sum and scatters each edge.
// A query scans the row until a match or its end; an entry read fetches one entry,
// and a query or read refused for range goes to the output after the check step.
// After reset the block is empty and unbuilt; a result waits while m_tready is low
// and the next input is still taken meanwhile.
module undirected_csr_builder
    import ucsr_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // node_a[9:0], node_b[19:10], edge_weight_in[51:20], slot[64:52], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[2:0]
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // weight_out[31:0], neighbor_out[41:32], degree_out[55:42],
    // node_count_out[66:56], entry_count_out[80:67], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]   m_tuser,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata
);

    ucsr_cmd_t cmd;
    ucsr_sts_t sts;

    // Sequencer.
    ucsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    ucsr_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the undirected CSR builder: loads edge lists, builds the rows
// and checks every result against an in-bench model of the block.
// Depends on ucsr_pkg and undirected_csr_builder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ucsr_pkg::*;

    localparam int NODE_CAP = DEF_MAX_NODES;
    localparam int EDGE_CAP = DEF_MAX_EDGES;
    localparam int ENTRY_CAP = 2 * EDGE_CAP;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   neighbour;
        logic [DEG_W-1:0]    degree;
        logic [NCNT_W-1:0]   node_count;
        logic [ECNT_W-1:0]   entry_count;
    } csr_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [ACT_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_we = 1'b0;
    logic                  cfg_wdata = 1'b0;

    // Model of the graph store, the row layout and the weight mode.
    logic                mode_weighted;
    logic [NODE_W-1:0]   edge_from [EDGE_CAP];
    logic [NODE_W-1:0]   edge_to [EDGE_CAP];
    logic [WEIGHT_W-1:0] edge_wt [EDGE_CAP];
    int                  n_edges;
    int                  n_nodes;
    bit                  rows_built;
    int                  row_base [NODE_CAP+1];
    int                  cursor [NODE_CAP+1];
    logic [NODE_W-1:0]   adj_node [ENTRY_CAP];
    logic [WEIGHT_W-1:0] adj_wt [ENTRY_CAP];

    csr_result_t pending_results[$];
    int          errors = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;
    longint      cycles = 0;

    undirected_csr_builder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Cycle counter guards against a hung block.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Degree count, prefix sum and scatter of every edge into both endpoint rows.
    function automatic void lay_out_rows();
        int pa;
        int pb;
        for (int i = 0; i <= NODE_CAP; i++)
            row_base[i] = 0;
        for (int i = 0; i < n_edges; i++)
        begin
            row_base[int'(edge_from[i]) + 1]++;
            row_base[int'(edge_to[i]) + 1]++;
        end
        for (int i = 1; i <= n_nodes; i++)
            row_base[i] += row_base[i-1];
        for (int i = 0; i <= NODE_CAP; i++)
            cursor[i] = row_base[i];
        for (int i = 0; i < n_edges; i++)
        begin
            pa = cursor[edge_from[i]]++;
            pb = cursor[edge_to[i]]++;
            adj_node[pa] = edge_to[i];
            adj_wt[pa] = edge_wt[i];
            adj_node[pb] = edge_from[i];
            adj_wt[pb] = edge_wt[i];
        end
        rows_built = 1'b1;
    endfunction

    // Works out the result of one action and updates the model state.
    function automatic csr_result_t csr_outcome(logic [ACT_W-1:0] act, int a, int b,
                                                logic [WEIGHT_W-1:0] w, int slot);
        csr_result_t r;
        bit          row_ok;
        bit          hit;
        int          rs;
        int          re;
        r = '0;
        rs = 0;
        re = 0;
        hit = 1'b0;
        row_ok = rows_built && a < n_nodes;
        if (row_ok)
        begin
            rs = row_base[a];
            re = row_base[a+1];
        end
        case (act)
            ACT_ADD:
            begin
                if (rows_built)
                    r.status = STS_PHASE;
                else if (n_edges >= EDGE_CAP)
                    r.status = STS_FULL;
                else
                begin
                    edge_from[n_edges] = NODE_W'(a);
                    edge_to[n_edges] = NODE_W'(b);
                    edge_wt[n_edges] = mode_weighted ? w : WEIGHT_ONE;
                    n_edges++;
                    if ((a > b ? a : b) + 1 > n_nodes)
                        n_nodes = (a > b ? a : b) + 1;
                end
            end
            ACT_BUILD:
            begin
                if (rows_built)
                    r.status = STS_PHASE;
                else
                    lay_out_rows();
            end
            ACT_QUERY:
            begin
                r.weight = WEIGHT_MISS;
                if (!rows_built)
                    r.status = STS_PHASE;
                else
                begin
                    if (row_ok)
                        r.degree = DEG_W'(re - rs);
                    if (!row_ok || b >= n_nodes)
                        r.status = STS_RANGE;
                    else
                    begin
                        r.status = STS_NOT_FOUND;
                        for (int i = rs; i < re && !hit; i++)
                        begin
                            if (int'(adj_node[i]) == b)
                            begin
                                hit = 1'b1;
                                r.status = STS_OK;
                                r.weight = mode_weighted ? adj_wt[i] : WEIGHT_ONE;
                            end
                        end
                    end
                end
            end
            ACT_READ:
            begin
                if (!rows_built)
                    r.status = STS_PHASE;
                else if (!row_ok)
                    r.status = STS_RANGE;
                else
                begin
                    r.degree = DEG_W'(re - rs);
                    if (slot >= re - rs)
                        r.status = STS_RANGE;
                    else
                    begin
                        r.neighbour = adj_node[rs + slot];
                        r.weight = mode_weighted ? adj_wt[rs + slot] : WEIGHT_ONE;
                    end
                end
            end
            ACT_CLEAR:
            begin
                n_edges = 0;
                n_nodes = 0;
                rows_built = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.node_count = NCNT_W'(n_nodes);
        r.entry_count = ECNT_W'(2 * n_edges);
        return r;
    endfunction

    // Offers one item after a random gap (none while calm) and records its expected result on transfer.
    task automatic send_item(logic [ACT_W-1:0] act, int a, int b,
                             logic [WEIGHT_W-1:0] w, int slot);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser <= act;
        s_tdata <= {7'd0, slot[SLOT_W-1:0], w, b[NODE_W-1:0], a[NODE_W-1:0]};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        // The block sees only the field bits, so the model does too.
        pending_results = {pending_results,
                           csr_outcome(act, int'(a[NODE_W-1:0]), int'(b[NODE_W-1:0]), w,
                                       int'(slot[SLOT_W-1:0]))};
        items_sent++;
    endtask

    // Drains all outstanding results so the register can be written safely.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_weighted = v;
    endtask

    // Edge extremes, every action, the phase errors and the ignored codes.
    task automatic test_directed();
        write_mode(1'b1);
        send_item(ACT_QUERY, 0, 0, '0, 0);
        send_item(ACT_READ, 0, 0, '0, 0);
        send_item(ACT_BUILD, 0, 0, '0, 0);
        send_item(ACT_CLEAR, 0, 0, '0, 0);
        send_item(ACT_ADD, 0, 1023, 32'h8000_0000, 0);
        send_item(ACT_ADD, 1023, 0, 32'h7FFF_FFFF, 8191);
        send_item(ACT_ADD, 5, 5, 32'hFFFF_FFFF, 0);
        send_item(ACT_ADD, 3, 7, 32'd42, 0);
        send_item(ACT_BUILD, 0, 0, '0, 0);
        send_item(ACT_BUILD, 0, 0, '0, 0);
        send_item(ACT_ADD, 1, 2, 32'd9, 0);
        send_item(ACT_QUERY, 0, 1023, '0, 0);
        send_item(ACT_QUERY, 1023, 0, '0, 0);
        send_item(ACT_QUERY, 5, 5, '0, 0);
        send_item(ACT_QUERY, 3, 8, '0, 0);
        send_item(ACT_READ, 5, 0, '0, 1);
        send_item(ACT_READ, 5, 0, '0, 2);
        send_item(ACT_READ, 7, 0, '0, 8191);
        for (int c = ACT_CLEAR + 1; c < 8; c++)
            send_item(ACT_W'(c), 1023, 1023, 32'hFFFF_FFFF, 8191);
        write_mode(1'b0);
        send_item(ACT_QUERY, 3, 7, '0, 0);
        send_item(ACT_CLEAR, 0, 0, '0, 0);
    endtask

    // Loads a larger graph over the whole id range, builds it and looks up some edges.
    task automatic test_large_graph();
        int i;
        write_mode(1'b1);
        calm = 1'b1;
        send_item(ACT_CLEAR, 0, 0, '0, 0);
        for (int k = 0; k < 200; k++)
            send_item(ACT_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom, 0);
        send_item(ACT_BUILD, 0, 0, '0, 0);
        for (int k = 0; k < 6; k++)
        begin
            i = $urandom_range(0, n_edges - 1);
            send_item(ACT_QUERY, int'(edge_to[i]), int'(edge_from[i]), '0, 0);
            send_item(ACT_READ, int'(edge_from[i]), 0, '0, $urandom_range(0, 3));
        end
        send_item(ACT_CLEAR, 0, 0, '0, 0);
        calm = 1'b0;
    endtask

    // Random graphs: mostly clean load, build and lookup sequences, with some noise.
    task automatic test_random_graphs();
        int span;
        int n_add;
        int n_look;
        int i;
        int a;
        int deg;
        int pick;
        while (items_sent < 850)
        begin
            write_mode($urandom_range(0, 1));
            calm = ($urandom_range(0, 3) == 0);
            span = ($urandom_range(0, 5) == 0) ? 1024 : $urandom_range(1, 40);
            n_add = $urandom_range(1, 30);
            n_look = $urandom_range(5, 30);
            send_item(ACT_CLEAR, 0, 0, '0, 0);
            if ($urandom_range(0, 3) == 0)
                send_item(ACT_W'($urandom_range(ACT_QUERY, ACT_READ)), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom, $urandom_range(0, 8191));
            for (int k = 0; k < n_add; k++)
                send_item(ACT_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                          $urandom, 0);
            send_item(ACT_BUILD, 0, 0, '0, 0);
            for (int k = 0; k < n_look; k++)
            begin
                pick = $urandom_range(0, 99);
                i = $urandom_range(0, n_edges - 1);
                a = $urandom_range(0, n_nodes - 1);
                deg = row_base[a+1] - row_base[a];
                if (pick < 40)
                begin
                    if ($urandom_range(0, 1))
                        send_item(ACT_QUERY, int'(edge_from[i]), int'(edge_to[i]), $urandom, 0);
                    else
                        send_item(ACT_QUERY, int'(edge_to[i]), int'(edge_from[i]), $urandom, 0);
                end
                else if (pick < 55)
                    send_item(ACT_QUERY, $urandom_range(0, n_nodes), $urandom_range(0, 1023),
                              $urandom, 0);
                else if (pick < 80)
                    send_item(ACT_READ, a, $urandom_range(0, 1023), $urandom,
                              $urandom_range(0, deg));
                else if (pick < 90)
                    send_item(ACT_READ, $urandom_range(0, 1023), 0, $urandom,
                              $urandom_range(0, 8191));
                else
                    send_item(ACT_W'($urandom_range(0, 7)), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom, $urandom_range(0, 8191));
            end
        end
        calm = 1'b0;
    endtask

    // Result side: random stall (none while calm) before each transfer.
    initial
    begin
        int stall;
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compares each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        csr_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer, status %0d", m_tuser);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("weight_out", $signed(want.weight), $signed(m_tdata[31:0]));
                check_field("neighbor_out", want.neighbour, m_tdata[41:32]);
                check_field("degree_out", want.degree, m_tdata[55:42]);
                check_field("node_count_out", want.node_count, m_tdata[66:56]);
                check_field("entry_count_out", want.entry_count, m_tdata[80:67]);
            end
        end
    end

    initial
    begin
        mode_weighted = 1'b0;
        n_edges = 0;
        n_nodes = 0;
        rows_built = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_large_graph();
        test_random_graphs();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
